// ===== design/utf8d_pkg.sv =====
`default_nettype none

package utf8d_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CP_W       = 21;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned RSP_USER_W = 2;

   localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

   // Everything one byte produces: a run of replacements, then an optional tail result.
   typedef struct packed {
      logic [1:0]      flush_cnt;
      logic            tail_vld;
      logic [CP_W-1:0] tail_cp;
      logic            tail_repl;
      logic            str_end;
   } bundle_type;

endpackage

`default_nettype wire

// ===== design/utf8_byte_stream_decoder.sv =====
// Each byte's results are registered in the result bundle before they appear on rsp.
// Throughput: one byte per cycle while rsp_tready is high and each byte gives at
// most one code point; a byte that flushes a broken or cut-off sequence sends up
// to four results, one per transfer. A one-entry skid register holds a byte that
// arrives while the output is busy, so req_tready never depends on rsp_tready.
// Reset (synchronous, active high) clears the pending sequence and all valids.
`default_nettype none

module utf8_byte_stream_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [utf8d_pkg::BYTE_W-1:0]        req_tdata,  // [7:0] data_byte
   input  wire logic                                req_tlast,  // string_end
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [utf8d_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // [20:0] code_point, zero pad
   output logic [utf8d_pkg::RSP_USER_W-1:0]         rsp_tuser,  // [0] replaced, [1] run_last
   output logic                                     rsp_tlast   // string_last
);

   import utf8d_pkg::*;

   // skid register
   logic              skid_vld_ff, skid_vld_in;
   logic [BYTE_W-1:0] skid_byte_ff;
   logic              skid_last_ff;

   // decoder state
   logic [CP_W-1:0]   partial_ff, partial_in;
   logic [1:0]        needed_ff, needed_in;
   logic [1:0]        taken_ff, taken_in;

   // result bundle being sent
   logic              bun_vld_ff, bun_vld_in;
   bundle_type        bun_ff, bun_in;
   logic [2:0]        bun_total_ff, bun_total_in;
   logic [1:0]        bun_idx_ff, bun_idx_in;

   logic              req_xfer, rsp_xfer, run_end, can_load, src_vld, load;
   logic [BYTE_W-1:0] src_byte;
   logic              src_last;

   // decode scratch
   logic              redo;
   logic [1:0]        taken_inc;
   logic [CP_W-1:0]   shifted;

   assign req_tready = !skid_vld_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = bun_vld_ff && rsp_tready;
   assign run_end    = ({1'b0, bun_idx_ff} == bun_total_ff - 3'd1);
   assign can_load   = !bun_vld_ff || (rsp_tready && run_end);

   assign src_vld  = skid_vld_ff || req_xfer;
   assign src_byte = skid_vld_ff ? skid_byte_ff : req_tdata;
   assign src_last = skid_vld_ff ? skid_last_ff : req_tlast;
   assign load     = src_vld && can_load;

   always_comb begin
      bun_in        = '0;
      bun_in.str_end = src_last;
      partial_in    = partial_ff;
      needed_in     = needed_ff;
      taken_in      = taken_ff;
      redo          = 1'b1;
      taken_inc     = taken_ff + 2'd1;
      shifted       = {partial_ff[CP_W-7:0], src_byte[5:0]};

      if (needed_ff != 2'd0) begin
         if (src_byte[7:6] == 2'b10) begin
            redo = 1'b0;
            if (taken_inc == needed_ff) begin
               bun_in.tail_vld = 1'b1;
               bun_in.tail_cp  = shifted;
               partial_in      = '0;
               needed_in       = 2'd0;
               taken_in        = 2'd0;
            end else if (src_last) begin
               // cut off: one replacement for the lead and each continuation
               bun_in.flush_cnt = taken_inc + 2'd1;
               partial_in       = '0;
               needed_in        = 2'd0;
               taken_in         = 2'd0;
            end else begin
               partial_in = shifted;
               taken_in   = taken_inc;
            end
         end else begin
            // broken sequence; the byte is decoded again below
            bun_in.flush_cnt = taken_inc;
            partial_in       = '0;
            needed_in        = 2'd0;
            taken_in         = 2'd0;
         end
      end

      if (redo) begin
         bun_in.tail_vld = 1'b1;
         if (!src_byte[7]) begin
            bun_in.tail_cp = {{(CP_W-BYTE_W){1'b0}}, src_byte};
         end else if (src_byte[7:5] == 3'b110 && !src_last) begin
            bun_in.tail_vld = 1'b0;
            partial_in      = {{(CP_W-5){1'b0}}, src_byte[4:0]};
            needed_in       = 2'd1;
            taken_in        = 2'd0;
         end else if (src_byte[7:4] == 4'b1110 && !src_last) begin
            bun_in.tail_vld = 1'b0;
            partial_in      = {{(CP_W-4){1'b0}}, src_byte[3:0]};
            needed_in       = 2'd2;
            taken_in        = 2'd0;
         end else if (src_byte[7:3] == 5'b11110 && !src_last) begin
            bun_in.tail_vld = 1'b0;
            partial_in      = {{(CP_W-3){1'b0}}, src_byte[2:0]};
            needed_in       = 2'd3;
            taken_in        = 2'd0;
         end else begin
            bun_in.tail_cp   = REPL_CP;
            bun_in.tail_repl = 1'b1;
         end
      end

      bun_total_in = {1'b0, bun_in.flush_cnt} + {2'b00, bun_in.tail_vld};
   end

   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff && can_load) begin
         skid_vld_in = 1'b0;
      end else if (req_xfer && !can_load) begin
         skid_vld_in = 1'b1;
      end

      bun_vld_in = bun_vld_ff;
      bun_idx_in = bun_idx_ff;
      if (load) begin
         bun_vld_in = (bun_total_in != 3'd0);
         bun_idx_in = 2'd0;
      end else if (rsp_xfer) begin
         if (run_end) begin
            bun_vld_in = 1'b0;
         end
         bun_idx_in = bun_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
         bun_vld_ff  <= 1'b0;
         bun_idx_ff  <= 2'd0;
         partial_ff  <= '0;
         needed_ff   <= 2'd0;
         taken_ff    <= 2'd0;
      end else begin
         skid_vld_ff <= skid_vld_in;
         bun_vld_ff  <= bun_vld_in;
         bun_idx_ff  <= bun_idx_in;
         if (load) begin
            partial_ff <= partial_in;
            needed_ff  <= needed_in;
            taken_ff   <= taken_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && !can_load) begin
         skid_byte_ff <= req_tdata;
         skid_last_ff <= req_tlast;
      end
      if (load) begin
         bun_ff       <= bun_in;
         bun_total_ff <= bun_total_in;
      end
   end

   logic in_flush;
   assign in_flush = (bun_idx_ff < bun_ff.flush_cnt);

   assign rsp_tvalid = bun_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CP_W){1'b0}}, in_flush ? REPL_CP : bun_ff.tail_cp};
   assign rsp_tuser  = {run_end, in_flush ? 1'b1 : bun_ff.tail_repl};
   assign rsp_tlast  = run_end && bun_ff.str_end;

endmodule

`default_nettype wire
